// ===== rtl/core/phtm_pkg.sv =====
// ----------------------------------------------------------------------------
// phtm_pkg: shared types and constants for the pipeline hazard timing model
// Stage item layout, instruction kind codes, predictor table sizing and the
// control bundles passed between the core and its stage cells.
// ----------------------------------------------------------------------------
`default_nettype none

package phtm_pkg;

   // field widths
   localparam int KIND_W = 4;
   localparam int REG_W  = 8;
   localparam int ADDR_W = 32;

   typedef logic [KIND_W-1:0] kind_type;

   // instruction kind codes
   localparam kind_type KIND_NOP      = 4'd0;
   localparam kind_type KIND_LOAD     = 4'd3;
   localparam kind_type KIND_BRANCH   = 4'd5;
   localparam kind_type KIND_SQUASHED = 4'd9;

   // stage positions along the chain
   localparam int NSTAGES = 5;
   localparam int S_IF    = 0;
   localparam int S_ID    = 1;
   localparam int S_EX    = 2;
   localparam int S_MEM   = 3;
   localparam int S_WB    = 4;

   // one-bit predictor table, indexed by target bits from TABLE_SHIFT up;
   // the entry count must be a power of two
   localparam int TABLE_ENTRIES = 128;
   localparam int TABLE_IDX_W   = $clog2(TABLE_ENTRIES);
   localparam int TABLE_SHIFT   = 4;

   // results one request may produce at most
   localparam int MAX_RESULTS = 12;
   localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);

   // contents of one pipeline stage
   typedef struct packed {
      kind_type          kind;
      logic [REG_W-1:0]  src_a;
      logic [REG_W-1:0]  src_b;
      logic [REG_W-1:0]  dst;
      logic [ADDR_W-1:0] pc;
      logic [ADDR_W-1:0] addr;
   } stage_type;

   // per cell shift control
   typedef struct packed {
      logic     shift;
      logic     fill;
      kind_type fill_kind;
   } cell_ctrl_type;

   // predictor table update
   typedef struct packed {
      logic                   en;
      logic [TABLE_IDX_W-1:0] idx;
      logic                   taken;
   } pred_wr_type;

   typedef enum logic [0:0] {
      ST_IDLE,
      ST_RUN
   } state_type;

endpackage

`default_nettype wire

// ===== rtl/core/phtm_if.sv =====
// ----------------------------------------------------------------------------
// phtm_if: channel interfaces of the pipeline hazard timing model
// Request, response and register write channels with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface phtm_req_if import phtm_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              end_of_trace;
   kind_type          kind;
   logic [REG_W-1:0]  src_a;
   logic [REG_W-1:0]  src_b;
   logic [REG_W-1:0]  dst;
   logic [ADDR_W-1:0] pc;
   logic [ADDR_W-1:0] target;

   modport source (output valid, end_of_trace, kind, src_a, src_b, dst, pc, target,
                   input ready);
   modport sink   (input valid, end_of_trace, kind, src_a, src_b, dst, pc, target,
                   output ready);
endinterface

interface phtm_rsp_if import phtm_pkg::*; ();
   logic              valid;
   logic              ready;
   kind_type          out_kind;
   logic [REG_W-1:0]  out_src_a;
   logic [REG_W-1:0]  out_src_b;
   logic [REG_W-1:0]  out_dst;
   logic [ADDR_W-1:0] out_pc;
   logic [ADDR_W-1:0] out_target;
   logic [ADDR_W-1:0] cycle;
   logic              last;

   modport source (output valid, out_kind, out_src_a, out_src_b, out_dst, out_pc,
                   out_target, cycle, last, input ready);
   modport sink   (input valid, out_kind, out_src_a, out_src_b, out_dst, out_pc,
                   out_target, cycle, last, output ready);
endinterface

interface phtm_csr_if ();
   logic valid;
   logic ready;
   logic prediction_mode;

   modport source (output valid, prediction_mode, input ready);
   modport sink   (input valid, prediction_mode, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/phtm_stage_cell.sv =====
// ----------------------------------------------------------------------------
// phtm_stage_cell: one pipeline stage of the timing model
// Holds one stage item; on a shift it takes its upstream neighbour's item or
// a filler (bubble or squash) and reports whether it will be empty.
// ----------------------------------------------------------------------------
`default_nettype none

module phtm_stage_cell import phtm_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  cell_ctrl_type ctrl,
   input  stage_type     up,
   output stage_type     item,
   output logic          empty_next
);

   stage_type item_ff;
   stage_type item_in;

   // next content: hold, take neighbour, or insert filler with zero fields
   always_comb begin
      item_in = item_ff;
      if (ctrl.shift) begin
         if (ctrl.fill) begin
            item_in      = '0;
            item_in.kind = ctrl.fill_kind;
         end else begin
            item_in = up;
         end
      end
   end

   assign empty_next = (item_in.kind == KIND_NOP);
   assign item       = item_ff;

   // stage register
   always_ff @(posedge clock) begin
      if (reset) begin
         item_ff <= '0;
      end else begin
         item_ff <= item_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/phtm_predictor.sv =====
// ----------------------------------------------------------------------------
// phtm_predictor: one-bit branch history table
// Single bit per entry in a memory with registered read, per entry valid bits
// so that unwritten entries read as not taken, and write-to-read forwarding.
// ----------------------------------------------------------------------------
`default_nettype none

module phtm_predictor import phtm_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [TABLE_IDX_W-1:0] rd_idx,
   input  pred_wr_type            wr,
   output logic                   rd_bit
);

   logic                     mem [TABLE_ENTRIES];
   logic [TABLE_ENTRIES-1:0] valid_ff;
   logic [TABLE_ENTRIES-1:0] valid_in;
   logic                     rd_raw_ff;
   logic                     rd_valid_ff;
   logic                     fwd_hit_ff;
   logic                     fwd_bit_ff;

   // valid bits set on first write
   always_comb begin
      valid_in = valid_ff;
      if (wr.en) begin
         valid_in[wr.idx] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
         fwd_hit_ff  <= 1'b0;
      end else begin
         valid_ff    <= valid_in;
         rd_valid_ff <= valid_ff[rd_idx];
         fwd_hit_ff  <= wr.en && (wr.idx == rd_idx);
      end
   end

   // memory write and registered read
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.idx] <= wr.taken;
      end
      rd_raw_ff  <= mem[rd_idx];
      fwd_bit_ff <= wr.taken;
   end

   assign rd_bit = fwd_hit_ff ? fwd_bit_ff : (rd_valid_ff & rd_raw_ff);

endmodule

`default_nettype wire

// ===== rtl/core/pipeline_hazard_timing_model_core.sv =====
// The first response of a request is loaded at the accepting edge and shows in the next
// cycle; one response per clock follows while the response side takes them. Load-use
// bubbles and mispredicts hold an instruction out of fetch (one simulated cycle per clock
// through the five-cell stage chain); a run, drain included, gives at most MAX_RESULTS
// responses. Reset clears the stages, cycle count, predictor valid bits and mode at once.
// ----------------------------------------------------------------------------
// pipeline_hazard_timing_model_core: five-stage pipeline timing model
// Runs simulated cycles per request until the instruction enters fetch,
// with load-use bubbles, one-bit branch prediction and drain on end of trace.
// ----------------------------------------------------------------------------
`default_nettype none

module pipeline_hazard_timing_model_core import phtm_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   phtm_req_if.sink          req,
   phtm_rsp_if.source        rsp,
   phtm_csr_if.sink          csr
);

   state_type              state_ff, state_in;
   stage_type              entry_ff, entry_in, entry_req, cur_entry;
   logic                   drain_ff, drain_in, cur_drain;
   logic                   pend_ff, pend_in, pend_cur, pend_next;
   logic                   finished_ff, finished_in;
   logic                   mode_ff, mode_in;
   logic [ADDR_W-1:0]      cycle_ff, cycle_in;
   logic [RES_CNT_W-1:0]   res_cnt_ff, res_cnt_in, res_cnt_cur, res_num;
   logic                   rsp_valid_ff, rsp_valid_in;
   stage_type              out_item_ff, out_item_in;
   logic [ADDR_W-1:0]      out_cycle_ff, out_cycle_in;
   logic                   out_last_ff, out_last_in;

   stage_type              stage_q   [NSTAGES];
   stage_type              stage_up  [NSTAGES];
   cell_ctrl_type          cell_ctrl [NSTAGES];
   logic [NSTAGES-1:0]     empty_next;

   logic                   slot_free, step, stall, done, cap_hit, all_empty_next;
   logic                   load_use, is_branch, taken, guess, mispredict;
   kind_type               fill_kind;
   logic                   pred_bit;
   logic [TABLE_IDX_W-1:0] rd_idx;
   pred_wr_type            pred_wr;

   // stage chain
   for (genvar g = 0; g < NSTAGES; g++) begin : g_cell
      if (g == 0) begin : g_head
         assign stage_up[g] = cur_entry;
      end else begin : g_link
         assign stage_up[g] = stage_q[g-1];
      end
      phtm_stage_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (cell_ctrl[g]),
         .up         (stage_up[g]),
         .item       (stage_q[g]),
         .empty_next (empty_next[g])
      );
   end

   // branch history table
   phtm_predictor u_pred (
      .clock  (clock),
      .reset  (reset),
      .rd_idx (rd_idx),
      .wr     (pred_wr),
      .rd_bit (pred_bit)
   );

   // request payload as a fetch item, zero on end of trace
   always_comb begin
      entry_req = '0;
      if (!req.end_of_trace) begin
         entry_req.kind  = req.kind;
         entry_req.src_a = req.src_a;
         entry_req.src_b = req.src_b;
         entry_req.dst   = req.dst;
         entry_req.pc    = req.pc;
         entry_req.addr  = req.target;
      end
   end

   assign cur_entry   = (state_ff == ST_IDLE) ? entry_req : entry_ff;
   assign cur_drain   = (state_ff == ST_IDLE) ? req.end_of_trace : drain_ff;
   assign pend_cur    = (state_ff == ST_RUN) && pend_ff;
   assign res_cnt_cur = (state_ff == ST_IDLE) ? '0 : res_cnt_ff;
   assign res_num     = res_cnt_cur + RES_CNT_W'(1);
   assign cap_hit     = (res_num == RES_CNT_W'(MAX_RESULTS));
   assign slot_free   = !rsp_valid_ff || rsp.ready;

   // hazard detection on the execute item
   assign load_use   = (stage_q[S_EX].kind == KIND_LOAD) &&
                       ((stage_q[S_EX].dst == stage_q[S_ID].src_a) ||
                        (stage_q[S_EX].dst == stage_q[S_ID].src_b));
   assign is_branch  = (stage_q[S_EX].kind == KIND_BRANCH);
   assign taken      = (stage_q[S_EX].addr == stage_q[S_ID].pc);
   assign guess      = mode_ff & pred_bit;
   assign mispredict = is_branch && (guess != taken);

   always_comb begin
      stall     = 1'b0;
      pend_next = 1'b0;
      fill_kind = KIND_NOP;
      priority if (pend_cur) begin
         stall     = 1'b1;
         fill_kind = KIND_SQUASHED;
      end else if (load_use) begin
         stall     = 1'b1;
      end else if (mispredict) begin
         stall     = 1'b1;
         pend_next = 1'b1;
         fill_kind = KIND_SQUASHED;
      end else begin
         stall     = 1'b0;
      end
   end

   // cell controls
   always_comb begin
      for (int s = 0; s < NSTAGES; s++) begin
         cell_ctrl[s].shift     = step;
         cell_ctrl[s].fill      = 1'b0;
         cell_ctrl[s].fill_kind = KIND_NOP;
      end
      cell_ctrl[S_IF].shift     = step && !stall;
      cell_ctrl[S_ID].shift     = step && !stall;
      cell_ctrl[S_EX].fill      = stall;
      cell_ctrl[S_EX].fill_kind = fill_kind;
   end

   assign all_empty_next = &empty_next;

   // table update and lookahead read for the next execute item
   assign pred_wr.en    = step && !pend_cur && is_branch && mode_ff;
   assign pred_wr.idx   = stage_q[S_EX].addr[TABLE_SHIFT +: TABLE_IDX_W];
   assign pred_wr.taken = taken;
   assign rd_idx = (step && !stall) ? stage_q[S_ID].addr[TABLE_SHIFT +: TABLE_IDX_W]
                                    : stage_q[S_EX].addr[TABLE_SHIFT +: TABLE_IDX_W];

   // sequencer: next state and handshake
   always_comb begin
      state_in    = state_ff;
      req.ready   = 1'b0;
      step        = 1'b0;
      done        = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req.ready = finished_ff || slot_free;
            step      = req.valid && !finished_ff && slot_free;
         end
         ST_RUN: begin
            step      = slot_free;
         end
         default: begin
            step      = 1'b0;
         end
      endcase
      if (step) begin
         done = cap_hit || (cur_drain ? all_empty_next : !stall);
         state_in = done ? ST_IDLE : ST_RUN;
      end
   end

   // request holding, counters and flags
   always_comb begin
      entry_in    = entry_ff;
      drain_in    = drain_ff;
      pend_in     = pend_ff;
      res_cnt_in  = res_cnt_ff;
      cycle_in    = cycle_ff;
      finished_in = finished_ff;
      if (req.valid && req.ready) begin
         entry_in = entry_req;
         drain_in = req.end_of_trace;
      end
      if (step) begin
         pend_in     = pend_next;
         res_cnt_in  = res_num;
         cycle_in    = cycle_ff + ADDR_W'(1);
         finished_in = finished_ff || (done && cur_drain);
      end
   end

   // response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      out_item_in  = out_item_ff;
      out_cycle_in = out_cycle_ff;
      out_last_in  = out_last_ff;
      if (step) begin
         rsp_valid_in = 1'b1;
         out_item_in  = stage_q[S_WB];
         out_cycle_in = cycle_ff + ADDR_W'(1);
         out_last_in  = done;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // mode register
   assign csr.ready = 1'b1;
   assign mode_in   = csr.valid ? csr.prediction_mode : mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         drain_ff     <= 1'b0;
         pend_ff      <= 1'b0;
         finished_ff  <= 1'b0;
         mode_ff      <= 1'b0;
         cycle_ff     <= '0;
         res_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         drain_ff     <= drain_in;
         pend_ff      <= pend_in;
         finished_ff  <= finished_in;
         mode_ff      <= mode_in;
         cycle_ff     <= cycle_in;
         res_cnt_ff   <= res_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff     <= entry_in;
      out_item_ff  <= out_item_in;
      out_cycle_ff <= out_cycle_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.out_kind   = out_item_ff.kind;
   assign rsp.out_src_a  = out_item_ff.src_a;
   assign rsp.out_src_b  = out_item_ff.src_b;
   assign rsp.out_dst    = out_item_ff.dst;
   assign rsp.out_pc     = out_item_ff.pc;
   assign rsp.out_target = out_item_ff.addr;
   assign rsp.cycle      = out_cycle_ff;
   assign rsp.last       = out_last_ff;

endmodule

`default_nettype wire

// ===== rtl/core/phtm_checker.sv =====
// ----------------------------------------------------------------------------
// phtm_checker: port level checks for the pipeline hazard timing model
// Response hold, cycle numbering and request gating while a run is open.
// ----------------------------------------------------------------------------
`default_nettype none

module phtm_checker import phtm_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [ADDR_W-1:0] rsp_cycle,
   input logic              rsp_last,
   input kind_type          rsp_kind
);

   logic [ADDR_W-1:0] prev_cycle_ff;

   // cycle number of the last response taken
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_cycle_ff <= '0;
      end else if (rsp_valid && rsp_ready) begin
         prev_cycle_ff <= rsp_cycle;
      end
   end

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_cycle) && $stable(rsp_last)
                                  && $stable(rsp_kind))
      else $error("stalled response changed");

   // responses number simulated cycles consecutively
   a_cycle_seq: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready |-> rsp_cycle == prev_cycle_ff + ADDR_W'(1))
      else $error("cycle number skipped or repeated");

   // no new request while a run has results still to come
   a_run_gate: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> !req_ready)
      else $error("request accepted during an open run");

   // a request is only taken once the previous run is closed
   a_accept_closed: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && rsp_valid |-> rsp_last)
      else $error("request accepted with a non-final response pending");

endmodule

bind pipeline_hazard_timing_model_core phtm_checker u_phtm_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req.valid),
   .req_ready (req.ready),
   .rsp_valid (rsp.valid),
   .rsp_ready (rsp.ready),
   .rsp_cycle (rsp.cycle),
   .rsp_last  (rsp.last),
   .rsp_kind  (rsp.out_kind)
);

`default_nettype wire
